### rtl/pcrf_pkg.sv
// pcrf_pkg: shared widths, register codes and reset values of the comb reverb
// used by the channel interfaces, the output scaler and the top level
`default_nettype none

package pcrf_pkg;

   // item and register port widths
   localparam int SAMPLE_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // register field layout
   localparam int DELAY_REG_W   = 36;
   localparam int DAMP_REG_W    = 48;
   localparam int DELAY_FIELD_W = 12;
   localparam int DLY_W         = DELAY_FIELD_W + 1;
   localparam int DAMP_W        = 8;
   localparam int COUNT_W       = 32;
   localparam int STEP_W        = 16;
   localparam int FADE_W        = 33;

   // accumulator of up to six 16-bit comb outputs
   localparam int SUM_W  = 19;
   localparam int PROD_W = SUM_W + FADE_W;

   // output limit
   localparam int CLAMP_LIM = 32000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DELAYS_FIRST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DELAYS_LAST  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DAMP_GAINS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FADE_START   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FADE_STEP    = 3'd4;

   // register reset values
   localparam logic [DELAY_REG_W-1:0] DELAYS_FIRST_RST = 36'd43630184400;
   localparam logic [DELAY_REG_W-1:0] DELAYS_LAST_RST  = 36'd48662940400;
   localparam logic [DAMP_REG_W-1:0]  DAMP_GAINS_RST   = 48'd112589990684262;
   localparam logic [COUNT_W-1:0]     FADE_START_RST   = 32'hFFFF_FFFF;
   localparam logic [STEP_W-1:0]      FADE_STEP_RST    = 16'd6493;

   // fade level of one in Q1.32
   localparam logic [FADE_W-1:0] FADE_ONE = {1'b1, {(FADE_W-1){1'b0}}};

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

`default_nettype wire

### rtl/pcrf_if.sv
// pcrf channel interfaces: input sample, output sample and register write
// depends on pcrf_pkg for widths and the sample type
`default_nettype none

interface pcrf_req_if import pcrf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface pcrf_rsp_if import pcrf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface pcrf_csr_if import pcrf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

### rtl/parallel_comb_reverb_fade.sv
// parallel_comb_reverb_fade: a bank of feedback combs sharing one delay memory and
// one damp multiplier under a sequencer, followed by the fade scaler.
// one item is taken at a time: a new one is accepted only once the last one's result is in the
// output register, set by the single memory read and write of each comb in turn through one
// multiplier
// reset: synchronous; then a clearing pass zeroes all COMB_COUNT*MAX_DELAY words of the
// delay memory, during which no item is accepted (register writes are taken throughout)
`default_nettype none

module parallel_comb_reverb_fade import pcrf_pkg::*; #(
   parameter int MAX_DELAY  = 4096,
   parameter int COMB_COUNT = 6
) (
   input wire logic clock,
   input wire logic reset,
   pcrf_req_if.sink   req_chan,
   pcrf_rsp_if.source rsp_chan,
   pcrf_csr_if.sink   csr_chan
);

   localparam int DEPTH = COMB_COUNT * MAX_DELAY;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = $clog2(MAX_DELAY);
   localparam int CW    = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;

   // sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_CALC  = 3'd3;
   localparam logic [2:0] ST_FADE  = 3'd4;
   localparam logic [2:0] ST_SCALE = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   // configuration registers
   logic [DELAY_REG_W-1:0] delays_first_ff, delays_first_in;
   logic [DELAY_REG_W-1:0] delays_last_ff, delays_last_in;
   logic [DAMP_REG_W-1:0]  damp_ff, damp_in;
   logic [COUNT_W-1:0]     fade_start_ff, fade_start_in;
   logic [STEP_W-1:0]      fade_step_ff, fade_step_in;

   // sequencer and comb state
   logic [2:0]             state_ff, state_in;
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   logic [CW-1:0]          comb_ff, comb_in;
   logic [PW-1:0]          pos_ff [COMB_COUNT];
   logic [PW-1:0]          pos_in;
   logic [PW-1:0]          pcur_ff, pcur_in;
   logic [AW-1:0]          addr_ff, addr_in;
   sample_type             half_ff, half_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [FADE_W-1:0]      fade_ff, fade_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sample_type             rsp_data_ff, rsp_data_in;

   // delay memory
   logic [SAMPLE_W-1:0]    mem_ff [DEPTH];
   logic [SAMPLE_W-1:0]    rd_data_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [SAMPLE_W-1:0]    mem_wdata;

   // per-comb datapath
   logic [2*DELAY_REG_W-1:0] delays_all;
   logic [DELAY_FIELD_W-1:0] delay_raw;
   logic [DLY_W-1:0]         delay_eff;
   logic [DAMP_W-1:0]        damp_cur;
   logic [PW-1:0]            pos_eff;
   logic [DLY_W-1:0]         pos_inc;
   logic signed [24:0]       damp_prod;
   logic signed [24:0]       damp_adj;
   logic signed [16:0]       damp_q;
   logic signed [16:0]       y_full;
   logic [SAMPLE_W-1:0]      y_wrap;

   logic                    req_accept;
   logic                    out_free;
   logic                    last_comb;
   logic                    scale_start;
   logic                    scale_done;
   sample_type              scale_result;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign last_comb  = (comb_ff == CW'(COMB_COUNT - 1));

   // register writes, unknown indexes ignored
   always_comb begin
      delays_first_in = delays_first_ff;
      delays_last_in  = delays_last_ff;
      damp_in         = damp_ff;
      fade_start_in   = fade_start_ff;
      fade_step_in    = fade_step_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            REG_DELAYS_FIRST: delays_first_in = csr_chan.wr_data[DELAY_REG_W-1:0];
            REG_DELAYS_LAST:  delays_last_in  = csr_chan.wr_data[DELAY_REG_W-1:0];
            REG_DAMP_GAINS:   damp_in         = csr_chan.wr_data[DAMP_REG_W-1:0];
            REG_FADE_START:   fade_start_in   = csr_chan.wr_data[COUNT_W-1:0];
            REG_FADE_STEP:    fade_step_in    = csr_chan.wr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // delay and damp of the current comb, with zero and over-capacity delays limited
   always_comb begin
      delays_all = {delays_last_ff, delays_first_ff};
      delay_raw  = delays_all[comb_ff * DELAY_FIELD_W +: DELAY_FIELD_W];
      damp_cur   = damp_ff[comb_ff * DAMP_W +: DAMP_W];
      delay_eff  = {1'b0, delay_raw};
      if (delay_eff == DLY_W'(0)) begin
         delay_eff = DLY_W'(1);
      end else if (delay_eff > DLY_W'(MAX_DELAY)) begin
         delay_eff = DLY_W'(MAX_DELAY);
      end
      pos_eff = (DLY_W'(pos_ff[comb_ff]) >= delay_eff) ? PW'(0) : pos_ff[comb_ff];
      pos_inc = DLY_W'(pcur_ff) + DLY_W'(1);
      pos_in  = (pos_inc >= delay_eff) ? PW'(0) : pos_inc[PW-1:0];
   end

   // damped feedback, product truncated toward zero, sum wrapped to 16 bits
   always_comb begin
      damp_prod = 25'($signed(rd_data_ff) * $signed({1'b0, damp_cur}));
      damp_adj  = damp_prod + (damp_prod[24] ? 25'sd255 : 25'sd0);
      damp_q    = damp_adj[24:8];
      y_full    = 17'(half_ff) + damp_q;
      y_wrap    = y_full[SAMPLE_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      comb_in      = comb_ff;
      pcur_in      = pcur_ff;
      addr_in      = addr_ff;
      half_in      = half_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      fade_in      = fade_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = y_wrap;
      scale_start  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               half_in  = req_chan.sample_in >>> 1;
               comb_in  = '0;
               sum_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            pcur_in  = pos_eff;
            addr_in  = AW'(comb_ff) * AW'(MAX_DELAY) + AW'(pos_eff);
            state_in = ST_CALC;
         end
         ST_CALC: begin
            mem_we = 1'b1;
            sum_in = sum_ff + SUM_W'($signed(y_wrap));
            if (last_comb) begin
               state_in = ST_FADE;
            end else begin
               comb_in  = comb_ff + CW'(1);
               state_in = ST_READ;
            end
         end
         ST_FADE: begin
            if (count_ff > fade_start_ff) begin
               fade_in = (fade_ff > FADE_W'(fade_step_ff)) ?
                         fade_ff - FADE_W'(fade_step_ff) : '0;
            end
            if (count_ff != {COUNT_W{1'b1}}) begin
               count_in = count_ff + COUNT_W'(1);
            end
            scale_start = 1'b1;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            if (scale_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = scale_result;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         comb_ff         <= '0;
         count_ff        <= '0;
         fade_ff         <= FADE_ONE;
         rsp_valid_ff    <= 1'b0;
         delays_first_ff <= DELAYS_FIRST_RST;
         delays_last_ff  <= DELAYS_LAST_RST;
         damp_ff         <= DAMP_GAINS_RST;
         fade_start_ff   <= FADE_START_RST;
         fade_step_ff    <= FADE_STEP_RST;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         comb_ff         <= comb_in;
         count_ff        <= count_in;
         fade_ff         <= fade_in;
         rsp_valid_ff    <= rsp_valid_in;
         delays_first_ff <= delays_first_in;
         delays_last_ff  <= delays_last_in;
         damp_ff         <= damp_in;
         fade_start_ff   <= fade_start_in;
         fade_step_ff    <= fade_step_in;
      end
   end

   // write positions, one per comb
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COMB_COUNT; i++) begin
            pos_ff[i] <= '0;
         end
      end else if (state_ff == ST_CALC) begin
         pos_ff[comb_ff] <= pos_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pcur_ff     <= pcur_in;
      addr_ff     <= addr_in;
      half_ff     <= half_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   // delay memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[addr_in];
   end

   // fade multiply and clamp
   pcrf_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start),
      .sum    (sum_ff),
      .fade   (fade_in),
      .done   (scale_done),
      .result (scale_result)
   );

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/pcrf_scale.sv
// pcrf_scale: two-stage fade multiply, truncation toward zero and clamp
// depends on pcrf_pkg for the sum, fade and product widths
`default_nettype none

module pcrf_scale import pcrf_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [SUM_W-1:0] sum,
   input  wire logic [FADE_W-1:0]       fade,
   output logic                         done,
   output sample_type                   result
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   sample_type                result_ff, result_in;
   logic signed [PROD_W-1:0]  prod_adj;
   logic signed [SUM_W-1:0]   quot;

   // stage one: a fade of exactly one is a shift, otherwise a 19 x 32 multiply
   always_comb begin
      if (fade[FADE_W-1]) begin
         prod_in = PROD_W'(sum) <<< (FADE_W - 1);
      end else begin
         prod_in = PROD_W'($signed(sum) * $signed({1'b0, fade[FADE_W-2:0]}));
      end
      busy_in = start;
   end

   // stage two: divide by 2^33 toward zero, then clamp
   always_comb begin
      prod_adj = prod_ff + (prod_ff[PROD_W-1] ? PROD_W'((64'd1 << FADE_W) - 64'd1)
                                              : PROD_W'(0));
      quot     = prod_adj[PROD_W-1:FADE_W];
      if (quot > SUM_W'(CLAMP_LIM)) begin
         result_in = SAMPLE_W'(CLAMP_LIM);
      end else if (quot < -SUM_W'(CLAMP_LIM)) begin
         result_in = -SAMPLE_W'(CLAMP_LIM);
      end else begin
         result_in = quot[SAMPLE_W-1:0];
      end
      done_in = busy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // payload stages, result held until the next product
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
      end
      if (busy_ff) begin
         result_ff <= result_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

### dv/parallel_comb_reverb_fade_tb.sv
// testbench of the comb reverb with fade-out: directed table, random phases
// and a full-speed fade run, checked item by item against the table or a predictor
// depends on pcrf_pkg, the pcrf channel interfaces and parallel_comb_reverb_fade
`timescale 1ns / 1ps

module parallel_comb_reverb_fade_tb import pcrf_pkg::*; ();

   localparam int COMBS         = 6;
   localparam int DEPTH         = 4096;
   localparam int LAT_TAIL      = 24;
   localparam int STALL_LIMIT   = 100000;
   localparam int PRESSURE_HOLD = 400;
   localparam int PRESSURE_AT   = 260;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 150;
   localparam int FAST_ITEMS    = 100;
   localparam int MISS_SHOWN    = 10;
   localparam longint FADE_DIV  = longint'(1) << 33;

   // indexes past the register list, ignored by the block
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

   typedef enum logic [0:0] {ROW_ITEM, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      sample_type            smp;
      bit                    typed;
      sample_type            want;
   } plan_row_type;

   logic clock;
   logic reset;

   pcrf_req_if req_if();
   pcrf_rsp_if rsp_if();
   pcrf_csr_if csr_if();

   parallel_comb_reverb_fade #(
      .MAX_DELAY(DEPTH),
      .COMB_COUNT(COMBS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   // predictor state and register copies
   logic signed [15:0]     echo_mem [COMBS][DEPTH];
   int                     tap_pos [COMBS];
   logic [COUNT_W-1:0]     n_seen;
   logic [FADE_W-1:0]      fade_gain;
   logic [DELAY_REG_W-1:0] dly_first;
   logic [DELAY_REG_W-1:0] dly_last;
   logic [DAMP_REG_W-1:0]  damp_set;
   logic [COUNT_W-1:0]     fade_from;
   logic [STEP_W-1:0]      fade_dec;

   sample_type   wet_due[$];
   plan_row_type plan[$];

   int  misses      = 0;
   int  items_sent  = 0;
   int  results_got = 0;
   int  regs_written = 0;
   bit  idle_on     = 1'b1;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   task automatic clear_model();
      for (int c = 0; c < COMBS; c++) begin
         tap_pos[c] = 0;
         for (int i = 0; i < DEPTH; i++) echo_mem[c][i] = '0;
      end
      n_seen    = '0;
      fade_gain = FADE_ONE;
      dly_first = DELAYS_FIRST_RST;
      dly_last  = DELAYS_LAST_RST;
      damp_set  = DAMP_GAINS_RST;
      fade_from = FADE_START_RST;
      fade_dec  = FADE_STEP_RST;
   endtask

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_DELAYS_FIRST: dly_first = data[DELAY_REG_W-1:0];
         REG_DELAYS_LAST:  dly_last  = data[DELAY_REG_W-1:0];
         REG_DAMP_GAINS:   damp_set  = data[DAMP_REG_W-1:0];
         REG_FADE_START:   fade_from = data[COUNT_W-1:0];
         REG_FADE_STEP:    fade_dec  = data[STEP_W-1:0];
         default: ;
      endcase
   endfunction

   // zero acts as one, and nothing beyond the line length is possible
   function automatic int tap_delay(int c);
      logic [DELAY_REG_W-1:0] reg_val;
      int d;
      reg_val = (c < 3) ? dly_first : dly_last;
      d = int'((reg_val >> (DELAY_FIELD_W * (c % 3))) & 36'hFFF);
      if (d == 0) d = 1;
      if (d > DEPTH) d = DEPTH;
      return d;
   endfunction

   // one dry sample through all combs, then fade, halve and clamp
   function automatic sample_type reverb_next(sample_type x);
      int half, damp, old, d, p, y;
      logic signed [15:0] w;
      longint acc, scaled;
      half = int'(x) >>> 1;
      acc  = 0;
      for (int c = 0; c < COMBS; c++) begin
         d = tap_delay(c);
         p = tap_pos[c];
         if (p >= d) p = 0;
         damp = int'(damp_set[8*c +: 8]);
         old  = int'(echo_mem[c][p]);
         y    = half + (old * damp) / 256;
         w    = y[15:0];
         echo_mem[c][p] = w;
         p++;
         if (p >= d) p = 0;
         tap_pos[c] = p;
         acc += longint'(w);
      end
      if (n_seen > fade_from) begin
         if (fade_gain > fade_dec) fade_gain = fade_gain - fade_dec;
         else fade_gain = '0;
      end
      if (n_seen != 32'hFFFF_FFFF) n_seen = n_seen + 1;
      scaled = (acc * longint'(fade_gain)) / FADE_DIV;
      if (scaled > CLAMP_LIM) scaled = CLAMP_LIM;
      if (scaled < -CLAMP_LIM) scaled = -CLAMP_LIM;
      return sample_type'(scaled);
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic sample_type pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return sample_type'($urandom_range(0, 65535));
      if (r < 85) begin
         case ($urandom_range(0, 3))
            0: return sample_type'(32767);
            1: return sample_type'(-32768);
            2: return sample_type'(0);
            default: return sample_type'(-1);
         endcase
      end
      return sample_type'(int'($urandom_range(0, 600)) - 300);
   endfunction

   function automatic logic [11:0] pick_delay(int mode);
      case (mode)
         0: return 12'($urandom_range(0, 8));
         1: return 12'($urandom_range(1, 300));
         2: return 12'($urandom_range(0, 4095));
         default: begin
            case ($urandom_range(0, 2))
               0: return 12'd0;
               1: return 12'd1;
               default: return 12'hFFF;
            endcase
         end
      endcase
   endfunction

   function automatic plan_row_type item_row(int s, bit typed, int want);
      plan_row_type r;
      r.kind  = ROW_ITEM;
      r.idx   = '0;
      r.data  = '0;
      r.smp   = sample_type'(s);
      r.typed = typed;
      r.want  = sample_type'(want);
      return r;
   endfunction

   function automatic plan_row_type write_row(logic [CSR_IDX_W-1:0] idx,
                                              logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r.kind  = ROW_WRITE;
      r.idx   = idx;
      r.data  = data;
      r.smp   = '0;
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   // offer one item, predict it once taken
   task automatic send_sample(sample_type s, bit typed, sample_type want);
      int gap;
      sample_type wet;
      gap = idle_on ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.sample_in <= s;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      wet = reverb_next(s);
      wet_due.push_back(typed ? want : wet);
      items_sent++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wr_data   <= data;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      apply_reg(idx, data);
      regs_written++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // stop offering and wait until every result is back
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (wet_due.size() != 0) @(posedge clock);
      repeat (LAT_TAIL) @(posedge clock);
   endtask

   // random setting of every register; the fast variant fades at full step from the start
   task automatic pick_config(bit fast_fade);
      logic [CSR_DATA_W-1:0] data;
      int mode;
      mode = $urandom_range(0, 3);
      data = {12'($urandom_range(0, 4095)), pick_delay(mode), pick_delay(mode),
              pick_delay(mode)};
      write_reg(REG_DELAYS_FIRST, data);
      data = {12'($urandom_range(0, 4095)), pick_delay(mode), pick_delay(mode),
              pick_delay(mode)};
      write_reg(REG_DELAYS_LAST, data);
      for (int c = 0; c < COMBS; c++) begin
         case ($urandom_range(0, 5))
            0: data[8*c +: 8] = 8'h00;
            1: data[8*c +: 8] = 8'hFF;
            default: data[8*c +: 8] = 8'($urandom_range(0, 255));
         endcase
      end
      write_reg(REG_DAMP_GAINS, data);
      data = {16'($urandom_range(0, 65535)), 32'($urandom())};
      if (fast_fade) data[COUNT_W-1:0] = '0;
      else begin
         case ($urandom_range(0, 3))
            0: data[COUNT_W-1:0] = 32'hFFFF_FFFF;
            1: data[COUNT_W-1:0] = '0;
            2: data[COUNT_W-1:0] = n_seen + 32'($urandom_range(0, 200));
            default: ;
         endcase
      end
      write_reg(REG_FADE_START, data);
      data = {32'($urandom()), 16'($urandom_range(0, 65535))};
      if (fast_fade) data[STEP_W-1:0] = 16'hFFFF;
      else begin
         case ($urandom_range(0, 3))
            0: data[STEP_W-1:0] = '0;
            1: data[STEP_W-1:0] = 16'hFFFF;
            2: data[STEP_W-1:0] = 16'($urandom_range(1, 64));
            default: ;
         endcase
      end
      write_reg(REG_FADE_STEP, data);
      if ($urandom_range(0, 2) == 0)
         write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                   {16'($urandom_range(0, 65535)), 32'($urandom())});
   endtask

   // ---------------------------------------------------------------- result check

   // receiver ready with random gaps while idle_on is set, and one long hold-off
   initial begin
      int hold_left;
      int gap_left;
      int g;
      bit held_once;
      hold_left = 0;
      gap_left  = 0;
      held_once = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_once && results_got >= PRESSURE_AT) begin
            held_once = 1'b1;
            hold_left = PRESSURE_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            g = idle_on ? pick_gap() : 0;
            if (g == 0) rsp_if.ready <= 1'b1;
            else begin
               rsp_if.ready <= 1'b0;
               gap_left = g - 1;
            end
         end
      end
   end

   // compare each taken result with the oldest pending sample
   always @(posedge clock) begin
      sample_type want;
      if (rsp_if.valid && rsp_if.ready) begin
         results_got++;
         if (wet_due.size() == 0) begin
            misses++;
            if (misses <= MISS_SHOWN)
               $display("result %0d: nothing pending, got %0d", results_got,
                        int'(rsp_if.sample_out));
         end else begin
            want = wet_due.pop_front();
            if (rsp_if.sample_out !== want) begin
               misses++;
               if (misses <= MISS_SHOWN)
                  $display("result %0d: sample_out expected %0d, got %0d", results_got,
                           int'(want), int'(rsp_if.sample_out));
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin
      int stall_run;
      stall_run = 0;
      while (stall_run < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            stall_run = 0;
         else
            stall_run++;
      end
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("parallel_comb_reverb_fade: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      plan_row_type row;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.sample_in = '0;
      csr_if.valid     = 1'b0;
      csr_if.reg_index = '0;
      csr_if.wr_data   = '0;
      clear_model();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset delays are all 2000 or more, so the first items only see zeros
      // and come out as three times half the input, clamped
      plan.push_back(item_row(0, 1, 0));
      plan.push_back(item_row(32767, 1, 32000));
      plan.push_back(item_row(-32768, 1, -32000));
      plan.push_back(item_row(1, 1, 0));
      plan.push_back(item_row(-1, 1, -3));
      plan.push_back(item_row(100, 1, 150));
      plan.push_back(item_row(-101, 1, -153));
      plan.push_back(item_row(21845, 1, 32000));
      plan.push_back(item_row(-21846, 1, -32000));
      // zero delay, shortened delays, longest delay, full damp, fade from the start
      plan.push_back(write_row(REG_DELAYS_FIRST, 48'hABC_001_001_000));
      plan.push_back(write_row(REG_DELAYS_LAST, 48'h5A5_FFF_002_003));
      plan.push_back(write_row(REG_DAMP_GAINS, 48'hFF_FF_80_01_00_FF));
      plan.push_back(write_row(REG_FADE_START, 48'h0));
      plan.push_back(write_row(REG_FADE_STEP, 48'h0000_0000_FFFF));
      plan.push_back(write_row(REG_SPARE_FIRST, 48'hFFFF_FFFF_FFFF));
      plan.push_back(write_row(REG_SPARE_LAST, 48'h1234_5678_9ABC));
      plan.push_back(item_row(32767, 0, 0));
      plan.push_back(item_row(32767, 0, 0));
      plan.push_back(item_row(32767, 0, 0));
      plan.push_back(item_row(32767, 0, 0));
      plan.push_back(item_row(-32768, 0, 0));
      plan.push_back(item_row(-32768, 0, 0));
      plan.push_back(item_row(-32768, 0, 0));
      plan.push_back(item_row(0, 0, 0));
      plan.push_back(item_row(1, 0, 0));
      plan.push_back(item_row(-1, 0, 0));
      plan.push_back(item_row(21845, 0, 0));
      plan.push_back(item_row(-21846, 0, 0));
      // fade held at the top of the count range, no step
      plan.push_back(write_row(REG_FADE_START, 48'hFFFF_FFFF_FFFF));
      plan.push_back(write_row(REG_FADE_STEP, 48'hFFFF_FFFF_0000));
      plan.push_back(item_row(12345, 0, 0));
      plan.push_back(item_row(-12345, 0, 0));
      plan.push_back(item_row(32767, 0, 0));

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_WRITE) begin
            settle();
            write_reg(row.idx, row.data);
         end else
            send_sample(row.smp, row.typed, row.want);
      end

      // random phases, each with its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         idle_on = ($urandom_range(0, 3) != 0);
         pick_config(1'b0);
         for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample(), 1'b0, '0);
      end

      // back-to-back items with the fade stepping at its largest rate
      settle();
      idle_on = 1'b0;
      pick_config(1'b1);
      for (int i = 0; i < FAST_ITEMS; i++) send_sample(pick_sample(), 1'b0, '0);
      settle();

      $display("%0d samples in, %0d results out, %0d register writes", items_sent,
               results_got, regs_written);
      $display("delays from zero to 4095, damps 0 to 255, fade held, slow and fastest");
      if (misses == 0 && wet_due.size() == 0)
         $display("parallel_comb_reverb_fade: match");
      else
         $display("parallel_comb_reverb_fade: mismatch");
      $finish;
   end

endmodule
